/* src/mrs_pkg.sv */
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int FrameBytesDef  = 64;
  localparam int RegDepthDef    = 256;
  localparam int MaxReadRegsDef = 16;

  localparam logic [7:0]  ADDR_ANY      = 8'hFF;
  localparam logic [7:0]  FN_READ       = 8'h03;
  localparam logic [7:0]  FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FN_WRITE_MANY = 8'h10;
  localparam logic [15:0] LOW_BYTE      = 16'h00FF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  typedef enum logic [1:0] {
    FM_IDX,
    FM_HI,
    FM_LO
  } fm_sel_t;

  typedef enum logic [2:0] {
    REG_NONE,
    REG_CLR,
    REG_ST_RD,
    REG_RD,
    REG_WR1,
    REG_WRM
  } reg_op_t;

  typedef enum logic [2:0] {
    ESRC_HDR,
    ESRC_CNT,
    ESRC_RHI,
    ESRC_RLO,
    ESRC_FM,
    ESRC_CRCL,
    ESRC_CRCH
  } esrc_t;

  typedef struct packed {
    logic    fm_rd;
    fm_sel_t fm_sel;
    logic    hold_ld;
    reg_op_t reg_op;
    logic    emit;
    esrc_t   esrc;
    logic    elast;
    logic    idx_clr;
    logic    idx_inc;
    logic    tx_init;
    logic    frame_clr;
  } mrs_cmd_t;

  typedef struct packed {
    logic rx_end;
    logic emit_ok;
    logic clr_last;
    logic idx_eq1;
    logic idx_eq5;
    logic idx_last_n;
    logic idx_last_len;
    logic go_read;
    logic go_w1;
    logic go_wm;
  } mrs_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/mrs_ctrl.sv */
`timescale 1ns / 1ps
module mrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::mrs_stat_t st,
  output mrs_pkg::mrs_cmd_t  cmd,
  output logic              rx_ready
);
  import mrs_pkg::*;

  typedef enum logic [18:0] {
    S_CLR  = 19'b0000000000000000001,
    S_IDLE = 19'b0000000000000000010,
    S_STA  = 19'b0000000000000000100,
    S_DEC  = 19'b0000000000000001000,
    S_RHDR = 19'b0000000000000010000,
    S_RCNT = 19'b0000000000000100000,
    S_RRD  = 19'b0000000000001000000,
    S_RHI  = 19'b0000000000010000000,
    S_RLO  = 19'b0000000000100000000,
    S_CRCL = 19'b0000000001000000000,
    S_CRCH = 19'b0000000010000000000,
    S_W1   = 19'b0000000100000000000,
    S_ERD  = 19'b0000001000000000000,
    S_EOUT = 19'b0000010000000000000,
    S_WRH  = 19'b0000100000000000000,
    S_WRL  = 19'b0001000000000000000,
    S_WWR  = 19'b0010000000000000000,
    S_WHDR = 19'b0100000000000000000,
    S_DONE = 19'b1000000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign rx_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.fm_sel = FM_IDX;
    cmd.reg_op = REG_NONE;
    cmd.esrc   = ESRC_HDR;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.reg_op  = REG_CLR;
        cmd.idx_inc = 1'b1;
        if (st.clr_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (st.rx_end) state_nxt = S_STA;
      end
      S_STA: begin
        cmd.reg_op = REG_ST_RD;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        cmd.tx_init = 1'b1;
        cmd.idx_clr = 1'b1;
        priority if (st.go_read) state_nxt = S_RHDR;
        else if (st.go_w1)       state_nxt = S_W1;
        else if (st.go_wm)       state_nxt = S_WRH;
        else                     state_nxt = S_DONE;
      end
      S_RHDR: begin
        cmd.esrc = ESRC_HDR;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          if (st.idx_eq1) state_nxt = S_RCNT;
        end
      end
      S_RCNT: begin
        cmd.esrc = ESRC_CNT;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_RRD;
        end
      end
      S_RRD: begin
        cmd.reg_op = REG_RD;
        state_nxt  = S_RHI;
      end
      S_RHI: begin
        cmd.esrc = ESRC_RHI;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_RLO;
        end
      end
      S_RLO: begin
        cmd.esrc = ESRC_RLO;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = st.idx_last_n ? S_CRCL : S_RRD;
        end
      end
      S_CRCL: begin
        cmd.esrc = ESRC_CRCL;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CRCH;
        end
      end
      S_CRCH: begin
        cmd.esrc  = ESRC_CRCH;
        cmd.elast = 1'b1;
        if (st.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_W1: begin
        cmd.reg_op = REG_WR1;
        state_nxt  = S_ERD;
      end
      S_ERD: begin
        cmd.fm_rd  = 1'b1;
        cmd.fm_sel = FM_IDX;
        state_nxt  = S_EOUT;
      end
      S_EOUT: begin
        cmd.esrc  = ESRC_FM;
        cmd.elast = st.idx_last_len;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = st.idx_last_len ? S_DONE : S_ERD;
        end
      end
      S_WRH: begin
        cmd.fm_rd  = 1'b1;
        cmd.fm_sel = FM_HI;
        state_nxt  = S_WRL;
      end
      S_WRL: begin
        cmd.fm_rd   = 1'b1;
        cmd.fm_sel  = FM_LO;
        cmd.hold_ld = 1'b1;
        state_nxt   = S_WWR;
      end
      S_WWR: begin
        cmd.reg_op  = REG_WRM;
        cmd.idx_inc = 1'b1;
        if (st.idx_last_n) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_WHDR;
        end else begin
          state_nxt = S_WRH;
        end
      end
      S_WHDR: begin
        cmd.esrc = ESRC_HDR;
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          if (st.idx_eq5) state_nxt = S_CRCL;
        end
      end
      S_DONE: begin
        cmd.frame_clr = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

/* src/mrs_dp.sv */
`timescale 1ns / 1ps
module mrs_dp #(
  parameter int FRAME_BYTES   = mrs_pkg::FrameBytesDef,
  parameter int REG_DEPTH     = mrs_pkg::RegDepthDef,
  parameter int MAX_READ_REGS = mrs_pkg::MaxReadRegsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::mrs_cmd_t  cmd,
  output mrs_pkg::mrs_stat_t st,
  input  logic              rx_take,
  input  logic [7:0]        rx_byte,
  input  logic              rx_end,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              tx_valid,
  input  logic              tx_ready,
  output logic [7:0]        tx_byte,
  output logic              tx_last
);
  import mrs_pkg::*;

  localparam int LW  = $clog2(FRAME_BYTES + 1);
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int AW  = $clog2(REG_DEPTH);
  localparam int IW  = (AW + 1 > 7) ? AW + 1 : 7;

  logic [7:0]    fmem [FRAME_BYTES];
  logic [15:0]   rmem [REG_DEPTH];

  logic [LW-1:0] len_r;
  logic          ovf_r;
  logic [15:0]   crc_r, txcrc_r;
  logic [7:0]    addr_r, fn_r, station_idx_r, fdata_r, hold_r;
  logic [15:0]   start_r, n_r, rdata_r;
  logic          st_ok_r;
  logic [IW-1:0] idx_r;
  logic          tx_valid_r, tx_last_r;
  logic [7:0]    tx_byte_r, ebyte;
  logic [FAW-1:0] fm_addr;
  logic [AW-1:0]  loop_addr;
  logic [7:0]    station, hdr_byte;
  logic [17:0]   end_addr, wm_need;
  logic          base_ok;

  // frame capture, running CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      crc_r <= CRC_INIT;
    end else if (cmd.frame_clr) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      crc_r <= CRC_INIT;
    end else if (rx_take) begin
      if (len_r < LW'(FRAME_BYTES)) len_r <= len_r + LW'(1);
      else                          ovf_r <= 1'b1;
      crc_r <= crc_byte(crc_r, rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && len_r < LW'(FRAME_BYTES)) begin
      fmem[FAW'(len_r)] <= rx_byte;
      unique case (len_r)
        LW'(0):  addr_r        <= rx_byte;
        LW'(1):  fn_r          <= rx_byte;
        LW'(2):  start_r[15:8] <= rx_byte;
        LW'(3):  start_r[7:0]  <= rx_byte;
        LW'(4):  n_r[15:8]     <= rx_byte;
        LW'(5):  n_r[7:0]      <= rx_byte;
        default: ;
      endcase
    end
    if (cmd.fm_rd) fdata_r <= fmem[fm_addr];
    if (cmd.hold_ld) hold_r <= fdata_r;
  end

  always_comb begin
    unique case (cmd.fm_sel)
      FM_HI:   fm_addr = FAW'(idx_r * 2 + 7);
      FM_LO:   fm_addr = FAW'(idx_r * 2 + 8);
      default: fm_addr = FAW'(idx_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) station_idx_r <= '0;
    else if (cfg_we) station_idx_r <= cfg_wdata;
  end

  assign loop_addr = AW'(start_r + 16'(idx_r));

  // register store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    unique case (cmd.reg_op)
      REG_CLR: rmem[AW'(idx_r)] <= '0;
      REG_ST_RD: begin
        rdata_r <= rmem[AW'(station_idx_r)];
        st_ok_r <= (32'(station_idx_r) < REG_DEPTH);
      end
      REG_RD:  rdata_r <= rmem[loop_addr];
      REG_WR1: rmem[AW'(start_r)] <= n_r;
      REG_WRM: rmem[loop_addr] <= {hold_r, fdata_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IW'(1);
  end

  // frame checks
  assign station  = st_ok_r ? rdata_r[7:0] : 8'h00;
  assign end_addr = {2'b00, start_r} + {2'b00, n_r};
  assign wm_need  = {1'b0, n_r, 1'b0} + 18'd9;
  assign base_ok  = !ovf_r && crc_r == 16'h0000 && len_r >= LW'(8)
                    && (addr_r == station || addr_r == ADDR_ANY);

  always_comb begin
    st.rx_end       = rx_take && rx_end;
    st.emit_ok      = !tx_valid_r || tx_ready;
    st.clr_last     = (idx_r == IW'(REG_DEPTH - 1));
    st.idx_eq1      = (idx_r == IW'(1));
    st.idx_eq5      = (idx_r == IW'(5));
    st.idx_last_n   = ({{(17 - IW){1'b0}}, idx_r} == ({1'b0, n_r} - 17'd1));
    st.idx_last_len = (idx_r == IW'(len_r - LW'(1)));
    st.go_read      = base_ok && fn_r == FN_READ && n_r != 16'h0000
                      && 32'(n_r) <= MAX_READ_REGS && 32'(end_addr) <= REG_DEPTH;
    st.go_w1        = base_ok && fn_r == FN_WRITE_ONE && 32'(start_r) < REG_DEPTH;
    st.go_wm        = base_ok && fn_r == FN_WRITE_MANY && n_r != 16'h0000
                      && 32'(end_addr) <= REG_DEPTH && {11'b0, len_r} >= wm_need[17:0];
  end

  always_comb begin
    unique case (idx_r[2:0])
      3'd0:    hdr_byte = addr_r;
      3'd1:    hdr_byte = fn_r;
      3'd2:    hdr_byte = start_r[15:8];
      3'd3:    hdr_byte = start_r[7:0];
      3'd4:    hdr_byte = n_r[15:8];
      default: hdr_byte = n_r[7:0];
    endcase
    unique case (cmd.esrc)
      ESRC_HDR:  ebyte = hdr_byte;
      ESRC_CNT:  ebyte = {n_r[6:0], 1'b0};
      ESRC_RHI:  ebyte = rdata_r[15:8];
      ESRC_RLO:  ebyte = rdata_r[7:0];
      ESRC_FM:   ebyte = fdata_r;
      ESRC_CRCL: ebyte = txcrc_r[7:0];
      default:   ebyte = txcrc_r[15:8];
    endcase
  end

  // hold the response CRC steady while its own two bytes go out
  always_ff @(posedge clk) begin
    if (cmd.tx_init) txcrc_r <= CRC_INIT;
    else if (cmd.emit && cmd.esrc != ESRC_CRCL && cmd.esrc != ESRC_CRCH)
      txcrc_r <= crc_byte(txcrc_r, ebyte);
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      tx_valid_r <= 1'b1;
    end else if (tx_ready) begin
      tx_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_byte_r <= ebyte;
      tx_last_r <= cmd.elast;
    end
  end

  assign tx_valid = tx_valid_r;
  assign tx_byte  = tx_byte_r;
  assign tx_last  = tx_last_r;

endmodule

/* src/modbus_rtu_slave_register_file_top.sv */
`timescale 1ns / 1ps
// Modbus RTU slave front end over a 16-bit register file.
// Input stream: one received byte per word in in_tdata, in_tlast on the last
// byte of a frame. Output stream: response bytes in wire order, out_tlast on
// the last byte. cfg_we/cfg_wdata pick the register whose low byte is the
// station address.
// Bytes are taken one per cycle while a frame is being received. After the
// closing word the controller checks CRC, address and function, then walks
// the register store (one port, registered read) and the frame buffer:
//   read n regs : 5 + 2n output words
//   write one   : the frame echoed
//   write n regs: 8 output words
// A dropped frame goes from decode straight to done. in_tready is low while a frame is served;
// the output register decouples the two sides, so the next frame can start
// while the final word waits. A receiver stall holds the controller in
// place with the word held steady on out_tdata.
// After reset the register store is cleared, one entry per cycle, with
// in_tready low; configuration writes are taken.
module modbus_rtu_slave_register_file_top #(
  parameter int FRAME_BYTES   = mrs_pkg::FrameBytesDef,
  parameter int REG_DEPTH     = mrs_pkg::RegDepthDef,
  parameter int MAX_READ_REGS = mrs_pkg::MaxReadRegsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mrs_pkg::*;

  mrs_cmd_t  cmd;
  mrs_stat_t st;
  logic      rx_ready;

  // accept a word only while the controller is waiting for bytes
  assign in_tready = rx_ready;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .rx_ready (rx_ready)
  );

  mrs_dp #(
    .FRAME_BYTES   (FRAME_BYTES),
    .REG_DEPTH     (REG_DEPTH),
    .MAX_READ_REGS (MAX_READ_REGS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .rx_take   (in_tvalid && rx_ready),
    .rx_byte   (in_tdata),
    .rx_end    (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tx_valid  (out_tvalid),
    .tx_ready  (out_tready),
    .tx_byte   (out_tdata),
    .tx_last   (out_tlast)
  );

endmodule

/* src/mrs_checker.sv */
`timescale 1ns / 1ps
module mrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // drop output and input readiness out of reset (clear pass runs)
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  // a closing word starts the service sequence
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after frame end");

  // a frame end cannot produce a word in the next cycle
  a_no_instant_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("response word too early");

endmodule

bind modbus_rtu_slave_register_file_top mrs_checker u_mrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
